// File: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// condition must hold on every clock outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: always");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implies");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/bsl_pkg.sv
`timescale 1ns / 1ps

package bsl_pkg;

    // default capacity of the list
    localparam int DEFAULT_DEPTH = 16;

    // field widths
    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // operation codes
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

// File: hw/rtl/bsl_ram.sv
`timescale 1ns / 1ps

module bsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/bounded_sequence_list_top.sv
`timescale 1ns / 1ps

// Bounded list of signed 32-bit values with push and pop at both ends. The
// elements live in a circular buffer held in two mirrored single-port-read
// RAMs (one read for the front, one for the back); push front and pop front
// move a head pointer instead of the data. A transaction is taken on any edge
// with start high; busy never rises, so one transaction can be issued every
// cycle. Its result appears on the result ports with o_valid high in the
// cycle right after the start cycle and is there for that cycle only, so the
// receiver must capture it then. The result is registered alongside the RAM read.
// Rejected pushes (full) and pops (empty) report a status and leave the list
// unchanged. No clearing pass runs after reset: entries are written before
// they are ever reported.

`include "assert_macros.svh"

module bounded_sequence_list_top import bsl_pkg::*; #(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [CMD_W-1:0]           i_cmd,
    input  logic signed [VALUE_W-1:0]  i_value,
    output logic                       o_valid,
    output logic [STATUS_W-1:0]        o_status,
    output logic [COUNT_W-1:0]         o_count,
    output logic signed [VALUE_W-1:0]  o_front_value,
    output logic signed [VALUE_W-1:0]  o_back_value
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef logic [AW-1:0] t_addr;
    typedef logic [AW:0]   t_sum;
    typedef logic [CW-1:0] t_count;

    // list state
    t_addr r_head, n_head;
    t_count r_count, n_count;

    // result stage
    logic                r_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_empty;
    logic                r_fwd_front;
    logic                r_fwd_back;
    logic [VALUE_W-1:0]  r_value;

    // ram ports
    logic               ram_we;
    t_addr              ram_waddr;
    t_addr              rd_front_addr;
    t_addr              rd_back_addr;
    logic [VALUE_W-1:0] q_front;
    logic [VALUE_W-1:0] q_back;

    logic   full;
    logic   empty;
    logic   push_ok;
    t_sum   back_sum;
    logic [CW+COUNT_W-1:0] count_ext;

    // wrap a sum of two in-range addresses back into the buffer
    function automatic t_addr wrap_addr(input t_sum s);
        t_sum w;
        w = (s >= t_sum'(DEPTH)) ? s - t_sum'(DEPTH) : s;
        return w[AW-1:0];
    endfunction

    assign full  = (r_count == t_count'(DEPTH));
    assign empty = (r_count == '0);
    assign busy  = 1'b0;

    // pointer and count update for the incoming operation
    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_status  = ST_DONE;
        push_ok   = 1'b0;
        ram_waddr = wrap_addr(t_sum'(r_head) + t_sum'(r_count));
        unique case (i_cmd)
            CMD_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    push_ok = 1'b1;
                    n_count = r_count + t_count'(1);
                end
            end
            CMD_PUSH_FRONT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    push_ok   = 1'b1;
                    n_head    = (r_head == '0) ? t_addr'(DEPTH - 1) : r_head - t_addr'(1);
                    ram_waddr = n_head;
                    n_count   = r_count + t_count'(1);
                end
            end
            CMD_POP_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - t_count'(1);
                end
            end
            CMD_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_head  = wrap_addr(t_sum'(r_head) + t_sum'(1));
                    n_count = r_count - t_count'(1);
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    assign ram_we = start && push_ok;

    // read addresses of the ends after the operation
    assign back_sum      = t_sum'(n_head) + t_sum'(n_count) - t_sum'(1);
    assign rd_front_addr = n_head;
    assign rd_back_addr  = wrap_addr(back_sum);

    // front copy of the element store
    bsl_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram_front (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_value),
        .i_raddr (rd_front_addr),
        .o_rdata (q_front)
    );

    // back copy of the element store
    bsl_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram_back (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_value),
        .i_raddr (rd_back_addr),
        .o_rdata (q_back)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= start;
            if (start) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
        end
    end

    // result payload, with forwarding of the element written this cycle
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_status    <= n_status;
            r_empty     <= (n_count == '0);
            r_fwd_front <= ram_we && (ram_waddr == rd_front_addr);
            r_fwd_back  <= ram_we && (ram_waddr == rd_back_addr);
            r_value     <= i_value;
        end
    end

    // count reported in its 5-bit field
    assign count_ext = {{COUNT_W{1'b0}}, r_count};

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_count       = count_ext[COUNT_W-1:0];
    assign o_front_value = r_empty ? '0 : (r_fwd_front ? r_value : q_front);
    assign o_back_value  = r_empty ? '0 : (r_fwd_back ? r_value : q_back);

    // checks
    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= t_count'(DEPTH))
    `ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, start && !busy, o_valid)
    `ASSERT_IMPLIES(a_full_status, i_clk, i_rst_n, o_valid && (o_status == ST_FULL), r_count == t_count'(DEPTH))
    `ASSERT_IMPLIES(a_empty_flag, i_clk, i_rst_n, o_valid, r_empty == (r_count == '0))

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import bsl_pkg::*;

    localparam int LIST_DEPTH  = DEFAULT_DEPTH;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 355;

    // one result transaction as the list reports it
    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        count;
        logic signed [VALUE_W-1:0] front_value;
        logic signed [VALUE_W-1:0] back_value;
    } list_result_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [CMD_W-1:0]          i_cmd = CMD_PUSH_BACK;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      o_valid;
    logic [STATUS_W-1:0]       o_status;
    logic [COUNT_W-1:0]        o_count;
    logic signed [VALUE_W-1:0] o_front_value;
    logic signed [VALUE_W-1:0] o_back_value;

    // shadow copy of the list contents
    logic signed [VALUE_W-1:0] shadow_elems [LIST_DEPTH];
    int                        shadow_held = 0;

    list_result_t pending_results [$];
    int           error_count = 0;
    int           gap_pct = 0;
    int           quiet_cycles = 0;

    bounded_sequence_list_top #(.DEPTH(LIST_DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_count       (o_count),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // apply one operation to the shadow list and return what the block should report
    function automatic list_result_t apply_list_op(input logic [CMD_W-1:0] cmd,
                                                   input logic signed [VALUE_W-1:0] value);
        list_result_t res;
        int           i;
        res.status = ST_DONE;
        if (cmd == CMD_PUSH_BACK || cmd == CMD_PUSH_FRONT) begin
            if (shadow_held >= LIST_DEPTH) begin
                res.status = ST_FULL;
            end else if (cmd == CMD_PUSH_BACK) begin
                shadow_elems[shadow_held] = value;
                shadow_held++;
            end else begin
                for (i = shadow_held; i > 0; i--)
                    shadow_elems[i] = shadow_elems[i-1];
                shadow_elems[0] = value;
                shadow_held++;
            end
        end else begin
            if (shadow_held == 0) begin
                res.status = ST_EMPTY;
            end else if (cmd == CMD_POP_BACK) begin
                shadow_held--;
            end else begin
                for (i = 0; i + 1 < shadow_held; i++)
                    shadow_elems[i] = shadow_elems[i+1];
                shadow_held--;
            end
        end
        res.count = COUNT_W'(shadow_held);
        if (shadow_held == 0) begin
            res.front_value = '0;
            res.back_value  = '0;
        end else begin
            res.front_value = shadow_elems[0];
            res.back_value  = shadow_elems[shadow_held-1];
        end
        return res;
    endfunction

    // issue one transaction, wait for it to be taken, then maybe idle
    task automatic send_list_op(input logic [CMD_W-1:0] cmd,
                                input logic signed [VALUE_W-1:0] value);
        start   <= 1'b1;
        i_cmd   <= cmd;
        i_value <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(apply_list_op(cmd, value));
        if ($urandom_range(99) < gap_pct) begin
            start   <= 1'b0;
            i_cmd   <= CMD_W'($urandom);
            i_value <= $urandom;
            @(posedge i_clk);
            while ($urandom_range(99) < gap_pct) @(posedge i_clk);
        end
    endtask

    // hold off the sender until every outstanding result is back
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // compare each result against the oldest outstanding prediction
    always @(posedge i_clk) begin
        list_result_t exp_res;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result with no transaction outstanding: status %0d count %0d",
                       o_status, o_count);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_status !== exp_res.status) begin
                    $error("status expected %0d actual %0d", exp_res.status, o_status);
                    error_count++;
                end
                if (o_count !== exp_res.count) begin
                    $error("count expected %0d actual %0d", exp_res.count, o_count);
                    error_count++;
                end
                if (o_front_value !== exp_res.front_value) begin
                    $error("front_value expected %0d actual %0d",
                           exp_res.front_value, o_front_value);
                    error_count++;
                end
                if (o_back_value !== exp_res.back_value) begin
                    $error("back_value expected %0d actual %0d",
                           exp_res.back_value, o_back_value);
                    error_count++;
                end
            end
        end
    end

    // count cycles in which neither side moves a transaction
    always @(posedge i_clk) begin
        if ((start && !busy && i_rst_n) || o_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    // pops on an empty list are rejected
    task automatic test_empty_pops();
        send_list_op(CMD_POP_BACK, 32'sd5);
        send_list_op(CMD_POP_FRONT, -32'sd5);
    endtask

    // extreme values through both ends
    task automatic test_extreme_values();
        send_list_op(CMD_PUSH_BACK, 32'sh7fff_ffff);
        send_list_op(CMD_PUSH_FRONT, 32'sh8000_0000);
        send_list_op(CMD_PUSH_BACK, -32'sd1);
        send_list_op(CMD_PUSH_FRONT, 32'sd0);
        send_list_op(CMD_POP_FRONT, 32'sh5555_5555);
        send_list_op(CMD_POP_BACK, 32'shaaaa_aaaa);
    endtask

    // fill to capacity, then pushes at either end are rejected
    task automatic test_fill_to_full();
        int k;
        for (k = shadow_held; k < LIST_DEPTH; k++)
            send_list_op((k % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom);
        send_list_op(CMD_PUSH_BACK, 32'sh1234_5678);
        send_list_op(CMD_PUSH_FRONT, -32'sh1234_5678);
    endtask

    // sender pauses until all results are in, then resumes
    task automatic test_drain_pause();
        int k;
        for (k = 0; k < 6; k++)
            send_list_op(CMD_W'($urandom), $urandom);
        wait_drained();
        for (k = 0; k < 4; k++)
            send_list_op(CMD_W'($urandom), $urandom);
    endtask

    // random traffic in bursts that lean toward filling, emptying or neither
    task automatic test_random_traffic(input int n_items, input int idle_pct);
        int                        sent;
        int                        burst_left;
        int                        push_pct;
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] value;
        gap_pct    = idle_pct;
        sent       = 0;
        burst_left = 0;
        push_pct   = 50;
        while (sent < n_items) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(40, 8);
                case ($urandom_range(2))
                    0: push_pct = 85;
                    1: push_pct = 15;
                    default: push_pct = 50;
                endcase
            end
            if ($urandom_range(99) < push_pct)
                cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            else
                cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
            case ($urandom_range(7))
                0: value = 32'sh7fff_ffff;
                1: value = 32'sh8000_0000;
                2: value = -32'sd1;
                default: value = $urandom;
            endcase
            send_list_op(cmd, value);
            sent++;
            burst_left--;
        end
    endtask

    // test sequence
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gap_pct = 0;
        test_empty_pops();
        test_extreme_values();
        test_fill_to_full();
        test_drain_pause();

        test_random_traffic(PHASE_ITEMS, 0);
        test_random_traffic(PHASE_ITEMS, 54);
        test_random_traffic(PHASE_ITEMS, 0);
        test_random_traffic(PHASE_ITEMS, 36);

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
